/* hw/rtl/present_block_encrypt_unit_defines.svh */
// ----------------------------------------------------------------------------
// present_block_encrypt_unit_defines.svh
// assertion macros used by the block encrypt unit checker
// ----------------------------------------------------------------------------
`ifndef PRESENT_BLOCK_ENCRYPT_UNIT_DEFINES_SVH
`define PRESENT_BLOCK_ENCRYPT_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PBE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// next-cycle implication, disabled during reset
`define PBE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

// next-cycle implication that also holds across reset
`define PBE_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: lbl");

`endif

/* hw/rtl/pbe_pkg.sv */
// ----------------------------------------------------------------------------
// pbe_pkg
// types, constants and round functions of the PRESENT-128 encrypt unit
// ----------------------------------------------------------------------------
package pbe_pkg;

    localparam int BLOCK_W = 64;
    localparam int KEY_W   = 128;
    localparam int RC_W    = 6;
    localparam int CTR_W   = 6;
    localparam int CIDX_W  = 2;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [KEY_W-1:0]   t_key;
    typedef logic [RC_W-1:0]    t_rc;
    typedef logic [CTR_W-1:0]   t_ctr;
    typedef logic [CIDX_W-1:0]  t_cidx;

    localparam t_cidx CFG_KEY_UPPER   = 2'd0;
    localparam t_cidx CFG_KEY_LOWER   = 2'd1;
    localparam t_cidx CFG_ROUND_COUNT = 2'd2;

    localparam t_rc RC_RESET = 6'd32;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    function automatic t_block sub_layer(input t_block s);
        t_block r;
        for (int n = 0; n < 16; n++) begin
            r[4*n +: 4] = SBOX[s[4*n +: 4]];
        end
        return r;
    endfunction

    // bit i goes to 16*i mod 63, bit 63 stays
    function automatic t_block perm_layer(input t_block s);
        t_block r;
        for (int i = 0; i < 64; i++) begin
            r[(i % 4) * 16 + i / 4] = s[i];
        end
        return r;
    endfunction

    function automatic t_key key_update(input t_key k, input t_ctr ctr);
        t_key nk;
        nk = {k[66:0], k[127:67]};
        nk[127:124] = SBOX[nk[127:124]];
        nk[123:120] = SBOX[nk[123:120]];
        nk[63:62]   = nk[63:62] ^ ctr[1:0];
        nk[67:64]   = nk[67:64] ^ ctr[5:2];
        return nk;
    endfunction

endpackage

/* hw/rtl/present_block_encrypt_unit.sv */
// ----------------------------------------------------------------------------
// present_block_encrypt_unit
// PRESENT-128 encryption, one cipher round per round stage
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | i_in_valid, o_in_ready, i_plain_block     | in
//  output  | o_out_valid, i_out_ready, o_cipher_block  | out
//  config  | i_cfg_we, i_cfg_index, i_cfg_data         | in
//
//  one word accepted per cycle while the output is not stalled; the pipeline is
//  one register stage for capture, MAX_ROUNDS - 1 round stages and the output stage
//  stages skipped by a smaller round count pass their word through unchanged
//  a stalled output holds the whole pipeline, so nothing is lost or repeated
//  synchronous active-low reset clears the valid bits and loads default config
// ----------------------------------------------------------------------------
module present_block_encrypt_unit #(
    parameter int MAX_ROUNDS = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  pbe_pkg::t_cidx  i_cfg_index,
    input  pbe_pkg::t_block i_cfg_data,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pbe_pkg::t_block i_plain_block,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output pbe_pkg::t_block o_cipher_block
);
    import pbe_pkg::*;

    localparam int LAST = MAX_ROUNDS - 1;

    t_block r_key_upper;
    t_block r_key_lower;
    t_rc    r_round_count;

    logic   r_vld [MAX_ROUNDS];
    t_block r_st  [MAX_ROUNDS];
    t_key   r_key [MAX_ROUNDS];

    logic   r_out_vld;
    t_block r_out;
    logic   en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_upper   <= '0;
            r_key_lower   <= '0;
            r_round_count <= RC_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_UPPER:   r_key_upper   <= i_cfg_data;
                CFG_KEY_LOWER:   r_key_lower   <= i_cfg_data;
                CFG_ROUND_COUNT: r_round_count <= i_cfg_data[RC_W-1:0];
                default: ;
            endcase
        end
    end

    assign en = !r_out_vld || i_out_ready;

    // capture stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_st[0]  <= i_plain_block;
            r_key[0] <= {r_key_upper, r_key_lower};
        end
    end

    // round stages
    for (genvar k = 1; k < MAX_ROUNDS; k++) begin : g_round
        logic   act;
        t_block n_st;
        t_key   n_key;

        assign act = (7'(k) < {1'b0, r_round_count});

        always_comb begin
            if (act) begin
                n_st  = perm_layer(sub_layer(r_st[k-1] ^ r_key[k-1][KEY_W-1:BLOCK_W]));
                n_key = key_update(r_key[k-1], CTR_W'(k));
            end else begin
                n_st  = r_st[k-1];
                n_key = r_key[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (en) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_st[k]  <= n_st;
                r_key[k] <= n_key;
            end
        end
    end

    // final whitening
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= r_st[LAST] ^ r_key[LAST][KEY_W-1:BLOCK_W];
        end
    end

    assign o_in_ready     = en;
    assign o_out_valid    = r_out_vld;
    assign o_cipher_block = r_out;

endmodule

/* hw/rtl/pbe_checker.sv */
// ----------------------------------------------------------------------------
// pbe_checker
// port-level checks of the PRESENT-128 encrypt unit, bound to the top level
// ----------------------------------------------------------------------------
`include "present_block_encrypt_unit_defines.svh"

module pbe_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            o_in_ready,
    input logic            o_out_valid,
    input logic            i_out_ready,
    input pbe_pkg::t_block o_cipher_block
);
    import pbe_pkg::*;

    // stalled result word stays offered
    `PBE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    // stalled result word keeps its value
    `PBE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(o_cipher_block))

    // an empty output stage never blocks the input
    `PBE_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_out_valid, o_in_ready)

    // reset leaves no result pending
    `PBE_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind present_block_encrypt_unit pbe_checker u_pbe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_cipher_block (o_cipher_block)
);
